### rtl/core/ftr_pkg.sv
// Shared types, constants and divider step functions of the fuzzy step and rate tuner.
// No dependencies; all other files in rtl/core refer to it by scoped names.
package ftr_pkg;

  localparam int unsigned FRONT_STAGES = 3;
  localparam int unsigned FDIV_STAGES  = 17;
  localparam int unsigned DFZ_STAGES   = 3;
  localparam int unsigned DDIV_STAGES  = 16;
  localparam int unsigned NUM_STAGES   = FRONT_STAGES + FDIV_STAGES + DFZ_STAGES + DDIV_STAGES;
  localparam int unsigned FDIV_BASE    = FRONT_STAGES;
  localparam int unsigned DFZ_BASE     = FRONT_STAGES + FDIV_STAGES;

  localparam logic [47:0] DELTA_RATIOS_RST = 48'd168888421987123;
  localparam logic [47:0] ALPHA_LEVELS_RST = 48'd33423838154752;
  localparam logic [47:0] RATE_LEVELS_RST  = 48'd278665423912960;

  localparam logic [16:0] ONE_Q16       = 17'd65536;
  localparam logic [15:0] ALPHA_DEFAULT = 16'd4096;
  localparam logic [15:0] RATE_DEFAULT  = 16'd55706;

  typedef enum logic [1:0] {
    CFG_DELTA_RATIOS = 2'd0,
    CFG_ALPHA_LEVELS = 2'd1,
    CFG_RATE_LEVELS  = 2'd2
  } cfg_idx_e;

  // how the delta memberships are formed once the quotient is known
  typedef enum logic [2:0] {
    D_NONE     = 3'd0,
    D_SAME     = 3'd1,
    D_NEAR_DIV = 3'd2,
    D_FAR_DIV  = 3'd3,
    D_NEAR     = 3'd4,
    D_FAR      = 3'd5
  } dcase_e;

  typedef enum logic [1:0] {
    F_NONE   = 2'd0,
    F_SAME   = 2'd1,
    F_BETTER = 2'd2,
    F_WORSE  = 2'd3
  } fcase_e;

  typedef struct packed {
    dcase_e      dcase;
    fcase_e      fcase;
    logic [31:0] d_num;
    logic [31:0] d_den;
    logic [31:0] f_num;
    logic [31:0] f_den;
  } front_t;

  typedef struct packed {
    dcase_e      dcase;
    fcase_e      fcase;
    logic [16:0] d_quo;
    logic [16:0] f_quo;
  } frac_t;

  typedef struct packed {
    logic [31:0] rem;
    logic        bit_o;
  } fstep_t;

  typedef struct packed {
    logic [18:0] rem;
    logic        bit_o;
  } dstep_t;

  function automatic fstep_t fdiv_step(input logic [32:0] r_in, input logic [31:0] den);
    fstep_t      res;
    logic [32:0] diff;
    diff      = r_in - {1'b0, den};
    res.bit_o = (r_in >= {1'b0, den});
    res.rem   = res.bit_o ? diff[31:0] : r_in[31:0];
    return res;
  endfunction

  function automatic dstep_t ddiv_step(input logic [19:0] r_in, input logic [18:0] den);
    dstep_t      res;
    logic [19:0] diff;
    diff      = r_in - {1'b0, den};
    res.bit_o = (r_in >= {1'b0, den});
    res.rem   = res.bit_o ? diff[18:0] : r_in[18:0];
    return res;
  endfunction

  function automatic logic [16:0] max17(input logic [16:0] a, input logic [16:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

### rtl/core/ftr_front.sv
// Front end: distances, span breakpoints and case classification (three stages).
// Depends on ftr_pkg.
module ftr_front (
  input  logic                    clk_i,
  input  logic [2:0]              en_i,
  input  logic [31:0]             cur_i,
  input  logic [31:0]             prev_i,
  input  logic [31:0]             best_i,
  input  logic [31:0]             worst_i,
  input  logic [47:0]             delta_ratios_i,
  output ftr_pkg::front_t         front_o
);

  logic [32:0] diff_bc, diff_bw, diff_cp;
  logic [32:0] neg_bc, neg_bw, neg_cp;
  logic [31:0] delta_d, span_d, ch_d;

  logic [31:0] delta0_q, span0_q, ch0_q;
  logic        neg0_q;

  logic [47:0] m0, m1, m2;
  logic [31:0] b0_q, b1_q, b2_q, delta1_q, span1_q, ch1_q;
  logic        neg1_q;

  ftr_pkg::front_t front_d, front_q;

  // stage 0: absolute differences
  always_comb begin
    diff_bc = {best_i[31], best_i} - {cur_i[31], cur_i};
    diff_bw = {best_i[31], best_i} - {worst_i[31], worst_i};
    diff_cp = {cur_i[31], cur_i} - {prev_i[31], prev_i};
    neg_bc  = 33'd0 - diff_bc;
    neg_bw  = 33'd0 - diff_bw;
    neg_cp  = 33'd0 - diff_cp;
    delta_d = diff_bc[32] ? neg_bc[31:0] : diff_bc[31:0];
    span_d  = diff_bw[32] ? neg_bw[31:0] : diff_bw[31:0];
    ch_d    = diff_cp[32] ? neg_cp[31:0] : diff_cp[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      delta0_q <= delta_d;
      span0_q  <= span_d;
      ch0_q    <= ch_d;
      neg0_q   <= diff_cp[32];
    end
  end

  // stage 1: breakpoints as span fractions
  always_comb begin
    m0 = 48'(delta_ratios_i[15:0])  * 48'(span0_q);
    m1 = 48'(delta_ratios_i[31:16]) * 48'(span0_q);
    m2 = 48'(delta_ratios_i[47:32]) * 48'(span0_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      b0_q     <= m0[47:16];
      b1_q     <= m1[47:16];
      b2_q     <= m2[47:16];
      delta1_q <= delta0_q;
      span1_q  <= span0_q;
      ch1_q    <= ch0_q;
      neg1_q   <= neg0_q;
    end
  end

  // stage 2: pick membership case and divider operands
  always_comb begin
    front_d.dcase = ftr_pkg::D_NONE;
    front_d.fcase = ftr_pkg::F_NONE;
    front_d.d_num = delta1_q - b0_q;
    front_d.d_den = b1_q - b0_q;
    front_d.f_num = ch1_q;
    front_d.f_den = span1_q;
    if (span1_q == 32'd0) begin
      front_d.dcase = ftr_pkg::D_SAME;
      front_d.fcase = ftr_pkg::F_SAME;
    end else begin
      if (delta1_q < b1_q) begin
        if (delta1_q < b0_q) begin
          front_d.dcase = ftr_pkg::D_SAME;
        end else begin
          front_d.dcase = ftr_pkg::D_NEAR_DIV;
        end
      end else if (delta1_q <= span1_q) begin
        if (delta1_q <= b2_q) begin
          front_d.d_num = delta1_q - b1_q;
          front_d.d_den = b2_q - b1_q;
          front_d.dcase = (b2_q == b1_q) ? ftr_pkg::D_NEAR : ftr_pkg::D_FAR_DIV;
        end else begin
          front_d.dcase = ftr_pkg::D_FAR;
        end
      end
      if (ch1_q == 32'd0) begin
        front_d.fcase = ftr_pkg::F_SAME;
      end else if (ch1_q <= span1_q) begin
        front_d.fcase = neg1_q ? ftr_pkg::F_BETTER : ftr_pkg::F_WORSE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

### rtl/core/ftr_frac_div.sv
// Two-lane pipelined restoring divider for the membership fractions, one quotient bit a stage.
// Depends on ftr_pkg.
module ftr_frac_div (
  input  logic                               clk_i,
  input  logic [ftr_pkg::FDIV_STAGES-1:0]    en_i,
  input  ftr_pkg::front_t                    front_i,
  output ftr_pkg::frac_t                     frac_o
);

  typedef struct packed {
    ftr_pkg::dcase_e dcase;
    ftr_pkg::fcase_e fcase;
    logic [31:0]     d_rem;
    logic [31:0]     d_den;
    logic [16:0]     d_quo;
    logic [31:0]     f_rem;
    logic [31:0]     f_den;
    logic [16:0]     f_quo;
  } fdiv_stage_t;

  fdiv_stage_t st_q [ftr_pkg::FDIV_STAGES];

  for (genvar j = 0; j < ftr_pkg::FDIV_STAGES; j++) begin : g_st
    logic [32:0]      d_in, f_in;
    logic [16:0]      dq_in, fq_in;
    fdiv_stage_t      src;
    ftr_pkg::fstep_t  ds, fs;
    fdiv_stage_t      st_d;

    if (j == 0) begin : g_first
      // numerator never exceeds the divisor, so the first step takes no shift
      always_comb begin
        src       = '0;
        src.dcase = front_i.dcase;
        src.fcase = front_i.fcase;
        src.d_den = front_i.d_den;
        src.f_den = front_i.f_den;
        d_in      = {1'b0, front_i.d_num};
        f_in      = {1'b0, front_i.f_num};
        dq_in     = '0;
        fq_in     = '0;
      end
    end else begin : g_next
      always_comb begin
        src   = st_q[j-1];
        d_in  = {st_q[j-1].d_rem, 1'b0};
        f_in  = {st_q[j-1].f_rem, 1'b0};
        dq_in = st_q[j-1].d_quo;
        fq_in = st_q[j-1].f_quo;
      end
    end

    always_comb begin
      ds          = ftr_pkg::fdiv_step(d_in, src.d_den);
      fs          = ftr_pkg::fdiv_step(f_in, src.f_den);
      st_d        = src;
      st_d.d_rem  = ds.rem;
      st_d.f_rem  = fs.rem;
      st_d.d_quo  = {dq_in[15:0], ds.bit_o};
      st_d.f_quo  = {fq_in[15:0], fs.bit_o};
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        st_q[j] <= st_d;
      end
    end
  end

  assign frac_o.dcase = st_q[ftr_pkg::FDIV_STAGES-1].dcase;
  assign frac_o.fcase = st_q[ftr_pkg::FDIV_STAGES-1].fcase;
  assign frac_o.d_quo = st_q[ftr_pkg::FDIV_STAGES-1].d_quo;
  assign frac_o.f_quo = st_q[ftr_pkg::FDIV_STAGES-1].f_quo;

endmodule

### rtl/core/ftr_defuzz.sv
// Memberships, rule evaluation and weighted-average defuzzification with rounding divider.
// Depends on ftr_pkg.
module ftr_defuzz (
  input  logic                                              clk_i,
  input  logic [ftr_pkg::DFZ_STAGES+ftr_pkg::DDIV_STAGES-1:0] en_i,
  input  ftr_pkg::frac_t                                    frac_i,
  input  logic [47:0]                                       alpha_levels_i,
  input  logic [47:0]                                       rate_levels_i,
  output logic [15:0]                                       step_gain_o,
  output logic [15:0]                                       move_rate_o
);

  localparam int unsigned DS = ftr_pkg::DFZ_STAGES;

  logic [16:0] d_same, d_near, d_far, f_better, f_same, f_worse;
  logic [16:0] ra_d [3];
  logic [16:0] rp_d [3];
  logic [16:0] ra_q [3];
  logic [16:0] rp_q [3];

  logic [32:0] pa_q [3];
  logic [32:0] pp_q [3];
  logic [18:0] sa_q, sp_q;

  logic [34:0] na_d, np_d, na_q, np_q;
  logic [18:0] da_q, dp_q;
  logic        za_q, zp_q;

  // stage 0: memberships and rule strengths
  always_comb begin
    d_same   = '0;
    d_near   = '0;
    d_far    = '0;
    f_better = '0;
    f_same   = '0;
    f_worse  = '0;
    case (frac_i.dcase)
      ftr_pkg::D_SAME: d_same = ftr_pkg::ONE_Q16;
      ftr_pkg::D_NEAR_DIV: begin
        d_near = frac_i.d_quo;
        d_same = ftr_pkg::ONE_Q16 - frac_i.d_quo;
      end
      ftr_pkg::D_FAR_DIV: begin
        d_far  = frac_i.d_quo;
        d_near = ftr_pkg::ONE_Q16 - frac_i.d_quo;
      end
      ftr_pkg::D_NEAR: d_near = ftr_pkg::ONE_Q16;
      ftr_pkg::D_FAR:  d_far  = ftr_pkg::ONE_Q16;
      default: ;
    endcase
    case (frac_i.fcase)
      ftr_pkg::F_SAME:   f_same   = ftr_pkg::ONE_Q16;
      ftr_pkg::F_BETTER: f_better = frac_i.f_quo;
      ftr_pkg::F_WORSE:  f_worse  = frac_i.f_quo;
      default: ;
    endcase
    ra_d[0] = f_better;
    ra_d[1] = ftr_pkg::max17(f_same, ftr_pkg::max17(d_same, d_near));
    ra_d[2] = ftr_pkg::max17(f_worse, d_far);
    rp_d[0] = ftr_pkg::max17(f_worse, d_far);
    rp_d[1] = ftr_pkg::max17(f_same, d_same);
    rp_d[2] = ftr_pkg::max17(f_better, d_near);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ra_q <= ra_d;
      rp_q <= rp_d;
    end
  end

  // stage 1: weighted products and rule sums
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int k = 0; k < 3; k++) begin
        pa_q[k] <= 33'(ra_q[k]) * 33'(alpha_levels_i[16*k +: 16]);
        pp_q[k] <= 33'(rp_q[k]) * 33'(rate_levels_i[16*k +: 16]);
      end
      sa_q <= 19'(ra_q[0]) + 19'(ra_q[1]) + 19'(ra_q[2]);
      sp_q <= 19'(rp_q[0]) + 19'(rp_q[1]) + 19'(rp_q[2]);
    end
  end

  // stage 2: numerators with half the divisor added for round-to-nearest
  always_comb begin
    na_d = 35'(pa_q[0]) + 35'(pa_q[1]) + 35'(pa_q[2]) + 35'(sa_q[18:1]);
    np_d = 35'(pp_q[0]) + 35'(pp_q[1]) + 35'(pp_q[2]) + 35'(sp_q[18:1]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      na_q <= na_d;
      np_q <= np_d;
      da_q <= sa_q;
      dp_q <= sp_q;
      za_q <= (sa_q == 19'd0);
      zp_q <= (sp_q == 19'd0);
    end
  end

  // quotient always fits 16 bits: numerator stays below 65536 times the sum
  typedef struct packed {
    logic [18:0] a_rem;
    logic [15:0] a_low;
    logic [18:0] a_den;
    logic [15:0] a_quo;
    logic        a_zero;
    logic [18:0] p_rem;
    logic [15:0] p_low;
    logic [18:0] p_den;
    logic [15:0] p_quo;
    logic        p_zero;
  } ddiv_stage_t;

  ddiv_stage_t st_q [ftr_pkg::DDIV_STAGES];

  for (genvar j = 0; j < ftr_pkg::DDIV_STAGES; j++) begin : g_st
    ddiv_stage_t     src, st_d;
    ftr_pkg::dstep_t as, ps;

    if (j == 0) begin : g_first
      always_comb begin
        src.a_rem  = na_q[34:16];
        src.a_low  = na_q[15:0];
        src.a_den  = da_q;
        src.a_quo  = '0;
        src.a_zero = za_q;
        src.p_rem  = np_q[34:16];
        src.p_low  = np_q[15:0];
        src.p_den  = dp_q;
        src.p_quo  = '0;
        src.p_zero = zp_q;
      end
    end else begin : g_next
      assign src = st_q[j-1];
    end

    always_comb begin
      as         = ftr_pkg::ddiv_step({src.a_rem, src.a_low[15]}, src.a_den);
      ps         = ftr_pkg::ddiv_step({src.p_rem, src.p_low[15]}, src.p_den);
      st_d       = src;
      st_d.a_rem = as.rem;
      st_d.p_rem = ps.rem;
      st_d.a_low = {src.a_low[14:0], 1'b0};
      st_d.p_low = {src.p_low[14:0], 1'b0};
      st_d.a_quo = {src.a_quo[14:0], as.bit_o};
      st_d.p_quo = {src.p_quo[14:0], ps.bit_o};
    end

    always_ff @(posedge clk_i) begin
      if (en_i[DS+j]) begin
        st_q[j] <= st_d;
      end
    end
  end

  assign step_gain_o = st_q[ftr_pkg::DDIV_STAGES-1].a_zero ? ftr_pkg::ALPHA_DEFAULT
                                                           : st_q[ftr_pkg::DDIV_STAGES-1].a_quo;
  assign move_rate_o = st_q[ftr_pkg::DDIV_STAGES-1].p_zero ? ftr_pkg::RATE_DEFAULT
                                                           : st_q[ftr_pkg::DDIV_STAGES-1].p_quo;

endmodule

### rtl/core/fuzzy_step_and_rate_tuner.sv
// Top level of the fuzzy step and rate tuner: stream ports, config registers, stage valids.
// Depends on ftr_pkg, ftr_front, ftr_frac_div and ftr_defuzz.

// Takes one item per clock while the input is ready and returns one result per item, in order,
// through 39 stages. The two divider pipelines retire one quotient bit per stage: 17 stages for
// the delta and change fractions, 16 for the weighted average. Every stage carries a valid bit,
// and a stage refills whenever it or some stage after it is empty or the output is ready, so an
// output stall only blocks the input once all 39 stages hold items. Write the configuration
// registers only while no item is in flight.
module fuzzy_step_and_rate_tuner (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // current [31:0], previous [63:32], best [95:64], worst [127:96] fitness
  input  logic [127:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // step_gain [15:0], move_rate [31:16]
  output logic [31:0]  m_axis_tdata_o,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [47:0]  cfg_wdata_i
);

  localparam int unsigned NS = ftr_pkg::NUM_STAGES;

  logic [47:0] delta_ratios_q, alpha_levels_q, rate_levels_q;
  logic [NS-1:0] v_q, v_d, en;

  ftr_pkg::front_t front;
  ftr_pkg::frac_t  frac;
  logic [15:0]     step_gain, move_rate;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_ratios_q <= ftr_pkg::DELTA_RATIOS_RST;
      alpha_levels_q <= ftr_pkg::ALPHA_LEVELS_RST;
      rate_levels_q  <= ftr_pkg::RATE_LEVELS_RST;
    end else if (cfg_we_i) begin
      case (ftr_pkg::cfg_idx_e'(cfg_idx_i))
        ftr_pkg::CFG_DELTA_RATIOS: delta_ratios_q <= cfg_wdata_i;
        ftr_pkg::CFG_ALPHA_LEVELS: alpha_levels_q <= cfg_wdata_i;
        ftr_pkg::CFG_RATE_LEVELS:  rate_levels_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // a stage may load when any stage at or after it is empty, or the output moves
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = m_axis_tready_i | ~(&v_q[NS-1:k]);
  end

  always_comb begin
    v_d = v_q;
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        v_d[k] = (k == 0) ? s_axis_tvalid_i : v_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  ftr_front u_front (
    .clk_i          (clk_i),
    .en_i           (en[ftr_pkg::FRONT_STAGES-1:0]),
    .cur_i          (s_axis_tdata_i[31:0]),
    .prev_i         (s_axis_tdata_i[63:32]),
    .best_i         (s_axis_tdata_i[95:64]),
    .worst_i        (s_axis_tdata_i[127:96]),
    .delta_ratios_i (delta_ratios_q),
    .front_o        (front)
  );

  ftr_frac_div u_frac_div (
    .clk_i   (clk_i),
    .en_i    (en[ftr_pkg::DFZ_BASE-1:ftr_pkg::FDIV_BASE]),
    .front_i (front),
    .frac_o  (frac)
  );

  ftr_defuzz u_defuzz (
    .clk_i          (clk_i),
    .en_i           (en[NS-1:ftr_pkg::DFZ_BASE]),
    .frac_i         (frac),
    .alpha_levels_i (alpha_levels_q),
    .rate_levels_i  (rate_levels_q),
    .step_gain_o    (step_gain),
    .move_rate_o    (move_rate)
  );

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = v_q[NS-1];
  assign m_axis_tdata_o  = {move_rate, step_gain};

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (&v_q))
    else $error("input blocked while a stage is empty");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> v_q[0])
    else $error("accepted item missing from first stage");

  a_out_from_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !$past(m_axis_tvalid_o) |-> $past(v_q[NS-2]))
    else $error("result appeared without a predecessor stage item");

endmodule

### dv/tb_fuzzy_step_and_rate_tuner.sv
// Self-checking testbench for fuzzy_step_and_rate_tuner: directed and random fitness items,
// random stream idling, register writes between phases. Depends on ftr_pkg and the RTL.
`timescale 1ns / 1ps

module tb_fuzzy_step_and_rate_tuner;
  import ftr_pkg::*;

  typedef struct packed {
    logic [31:0] worst;
    logic [31:0] best;
    logic [31:0] prev;
    logic [31:0] cur;
  } cand_t;

  typedef struct packed {
    logic [15:0] rate;
    logic [15:0] gain;
  } tune_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [127:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [31:0]  m_axis_tdata_o;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [47:0]  cfg_wdata_i = '0;

  fuzzy_step_and_rate_tuner dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [47:0] ratios_q = DELTA_RATIOS_RST;
  logic [47:0] alphas_q = ALPHA_LEVELS_RST;
  logic [47:0] rates_q  = RATE_LEVELS_RST;

  cand_t cand_q[$];
  tune_t tune_exp_q[$];
  int    n_err = 0;
  int    n_sent = 0;
  int    n_seen = 0;
  int    n_dflt = 0;
  bit    idle_en = 1'b1;
  // input item taken at the last rising edge
  logic  in_acc = 1'b0;

  function automatic logic [15:0] weighted_avg(input logic [16:0] r[3], input logic [47:0] lv,
                                               input logic [15:0] dflt);
    logic [63:0] sum, num, q;
    sum = r[0] + r[1] + r[2];
    if (sum == 0) return dflt;
    num = 0;
    for (int k = 0; k < 3; k++) num += 64'(r[k]) * 64'(lv[16*k +: 16]);
    q = (num + sum / 2) / sum;
    return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic tune_t tune_predict(input cand_t c);
    longint cur, prv, bst, wst;
    logic [63:0] delta, span, ch, b0, b1, b2, m;
    logic [16:0] dm[3], fm[3], ra[3], rp[3];
    tune_t t;
    cur = $signed(c.cur); prv = $signed(c.prev);
    bst = $signed(c.best); wst = $signed(c.worst);
    delta = (bst >= cur) ? bst - cur : cur - bst;
    span  = (bst >= wst) ? bst - wst : wst - bst;
    ch    = (cur >= prv) ? cur - prv : prv - cur;
    dm = '{default: '0}; fm = '{default: '0};
    if (span == 0) begin
      dm[0] = ONE_Q16; fm[1] = ONE_Q16;
    end else begin
      b0 = (64'(ratios_q[15:0])  * span) >> 16;
      b1 = (64'(ratios_q[31:16]) * span) >> 16;
      b2 = (64'(ratios_q[47:32]) * span) >> 16;
      if (delta < b1) begin
        if (delta < b0) dm[0] = ONE_Q16;
        else begin
          dm[1] = 17'(((delta - b0) << 16) / (b1 - b0));
          dm[0] = ONE_Q16 - dm[1];
        end
      end else if (delta <= span) begin
        if (delta <= b2) begin
          if (b2 == b1) dm[1] = ONE_Q16;
          else begin
            dm[2] = 17'(((delta - b1) << 16) / (b2 - b1));
            dm[1] = ONE_Q16 - dm[2];
          end
        end else dm[2] = ONE_Q16;
      end
      if (ch == 0) fm[1] = ONE_Q16;
      else if (ch <= span) begin
        m = (ch << 16) / span;
        if (cur < prv) fm[0] = 17'(m); else fm[2] = 17'(m);
      end
    end
    ra[0] = fm[0];
    ra[1] = max17(fm[1], max17(dm[0], dm[1]));
    ra[2] = max17(fm[2], dm[2]);
    rp[0] = max17(fm[2], dm[2]);
    rp[1] = max17(fm[1], dm[0]);
    rp[2] = max17(fm[0], dm[1]);
    t.gain = weighted_avg(ra, alphas_q, ALPHA_DEFAULT);
    t.rate = weighted_avg(rp, rates_q, RATE_DEFAULT);
    return t;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH t=%0t %s", $time, msg);
    n_err++;
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || in_acc) begin
        if (cand_q.size() > 0 && !(idle_en && $urandom_range(99) < 17)) begin
          s_axis_tdata_i  <= cand_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= !(idle_en && $urandom_range(99) < 17);
    end
  end

  // monitor: input acceptance feeds the predictor, output acceptance is checked
  always @(posedge clk_i) begin
    tune_t got, want;
    in_acc <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      tune_exp_q.push_back(tune_predict(s_axis_tdata_i));
      n_sent++;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      n_seen++;
      if (tune_exp_q.size() == 0) report_mismatch("result with nothing expected");
      else begin
        want = tune_exp_q.pop_front();
        if (want.gain == ALPHA_DEFAULT && want.rate == RATE_DEFAULT) n_dflt++;
        if (got.gain !== want.gain)
          report_mismatch($sformatf("step_gain %0d exp %0d", got.gain, want.gain));
        if (got.rate !== want.rate)
          report_mismatch($sformatf("move_rate %0d exp %0d", got.rate, want.rate));
      end
    end
  end

  function automatic logic [31:0] fit_rand();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'($signed($urandom_range(8000)) - 4000);
      default: return 32'($signed($urandom_range(400000)) - 200000);
    endcase
  endfunction

  // best/worst first, then place cur and prev relative to the span
  function automatic cand_t cand_rand();
    cand_t c;
    longint b, w, s;
    c.best = fit_rand(); c.worst = fit_rand();
    if ($urandom_range(9) == 0) c.worst = c.best;
    b = $signed(c.best); w = $signed(c.worst); s = w - b;
    if ($urandom_range(3) == 0) c.cur = fit_rand();
    else c.cur = 32'(b + (s * longint'($urandom_range(1300))) / 1000);
    case ($urandom_range(3))
      0: c.prev = c.cur;
      1: c.prev = fit_rand();
      default: c.prev = 32'(longint'($signed(c.cur))
                            + (s * (longint'($urandom_range(2400)) - 1200)) / 1000);
    endcase
    return c;
  endfunction

  task automatic wait_drained();
    while (cand_q.size() > 0 || s_axis_tvalid_i || tune_exp_q.size() > 0) @(posedge clk_i);
    repeat (NUM_STAGES + 5) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [47:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DELTA_RATIOS: ratios_q = val;
      CFG_ALPHA_LEVELS: alphas_q = val;
      default:          rates_q  = val;
    endcase
  endtask

  initial begin
    cand_t c;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: extremes, zero span, zero change, |fi| > 1, beyond span, coincident points
    cand_q.push_back('{worst: 32'd0, best: 32'd0, prev: 32'd0, cur: 32'd0});
    cand_q.push_back('{worst: 32'h8000_0000, best: 32'h7FFF_FFFF,
                       prev: 32'h7FFF_FFFF, cur: 32'h8000_0000});
    cand_q.push_back('{worst: 32'h7FFF_FFFF, best: 32'h8000_0000,
                       prev: 32'h8000_0000, cur: 32'h7FFF_FFFF});
    cand_q.push_back('{worst: 32'hFFFF_FFFF, best: 32'hFFFF_FFFF,
                       prev: 32'h1234_5678, cur: 32'hFFFF_FFFF});
    cand_q.push_back('{worst: 32'd100, best: 32'd0, prev: 32'd50, cur: 32'd50});
    cand_q.push_back('{worst: 32'd100, best: 32'd0, prev: 32'd0, cur: 32'd500});
    cand_q.push_back('{worst: 32'd100, best: 32'd0, prev: 32'd90, cur: 32'd30});
    cand_q.push_back('{worst: 32'd100, best: 32'd0, prev: 32'd10, cur: 32'd50});
    cand_q.push_back('{worst: 32'd100, best: 32'd0, prev: 32'd300, cur: 32'd10});
    cand_q.push_back('{worst: 32'd100, best: 32'd0, prev: 32'd40, cur: 32'd40});
    cand_q.push_back('{worst: 32'd100, best: 32'd0, prev: 32'd70, cur: 32'd60});
    cand_q.push_back('{worst: 32'd100, best: 32'd0, prev: 32'd100, cur: 32'd100});
    for (int i = 0; i < 8; i++) cand_q.push_back(cand_rand());
    wait_drained();

    // phases of register settings, extremes included; second phase without idling
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_DELTA_RATIOS, 48'h0);
          write_reg(CFG_ALPHA_LEVELS, 48'hFFFF_FFFF_FFFF);
          write_reg(CFG_RATE_LEVELS,  48'h0);
        end
        1: begin
          write_reg(CFG_DELTA_RATIOS, 48'hFFFF_FFFF_FFFF);
          write_reg(CFG_ALPHA_LEVELS, 48'h0);
          write_reg(CFG_RATE_LEVELS,  48'hFFFF_FFFF_FFFF);
        end
        2: write_reg(CFG_DELTA_RATIOS, {16'd26214, 16'd26214, 16'd13107}); // b1 == b2
        3: write_reg(CFG_DELTA_RATIOS, {16'd13107, 16'd39322, 16'd52428}); // unordered
        4: begin
          write_reg(CFG_DELTA_RATIOS, 48'({$urandom(), $urandom()}));
          write_reg(CFG_ALPHA_LEVELS, 48'({$urandom(), $urandom()}));
          write_reg(CFG_RATE_LEVELS,  48'({$urandom(), $urandom()}));
        end
        default: begin
          write_reg(CFG_DELTA_RATIOS, DELTA_RATIOS_RST);
          write_reg(CFG_ALPHA_LEVELS, ALPHA_LEVELS_RST);
          write_reg(CFG_RATE_LEVELS,  RATE_LEVELS_RST);
        end
      endcase
      idle_en = (ph != 1);
      for (int i = 0; i < 100; i++) begin
        c = cand_rand();
        cand_q.push_back(c);
      end
      wait_drained();
    end

    $display("covered %0d items in 8 phases, incl. zero span, extreme breakpoints and levels",
             n_sent);
    $display("%0d results checked, %0d hit the default levels", n_seen, n_dflt);
    if (n_err == 0 && tune_exp_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule

### fuzzy_step_and_rate_tuner.f
rtl/core/ftr_pkg.sv
rtl/core/ftr_front.sv
rtl/core/ftr_frac_div.sv
rtl/core/ftr_defuzz.sv
rtl/core/fuzzy_step_and_rate_tuner.sv
dv/tb_fuzzy_step_and_rate_tuner.sv
